// ----- hw/rtl/tte_pkg.sv -----
// Typical testor enumerator: shared types, codes and sizing constants.
// No dependencies; imported by tte_row_check, the top level and the bench.
`timescale 1ns / 1ps

package tte_pkg;

  // Sizing
  localparam int MAX_ROWS_DEF = 64;             // default row store depth
  localparam int MAX_COLS     = 16;             // columns of the matrix
  localparam int NCOLS_W      = 5;              // width of the num_cols register
  localparam int CAND_W       = MAX_COLS + 1;   // candidate mask plus end marker
  localparam logic [NCOLS_W-1:0] NCOLS_RESET = NCOLS_W'(MAX_COLS);

  // Transaction opcodes
  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_FETCH  = 2'd1,
    ACT_CLEAR  = 2'd2
  } act_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_STORED = 2'd0,
    ST_FOUND  = 2'd1,
    ST_DONE   = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } fsm_state_t;

  // Sequencer to row checker
  typedef struct packed {
    logic clear;   // start a fresh candidate
    logic load;    // a row word is valid this cycle
  } chk_ctrl_t;

  // Row checker to sequencer
  typedef struct packed {
    logic miss;    // row has no 1 in any chosen column
    logic typical; // every chosen column owns a row so far
  } chk_stat_t;

endpackage

// ----- hw/rtl/tte_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the rows of the basic matrix.
`timescale 1ns / 1ps

module tte_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hw/rtl/tte_row_check.sv -----
// Shared row check unit: tests one stored row per cycle against a candidate
// mask and accumulates the set of columns that own a row. Uses tte_pkg.
`timescale 1ns / 1ps

module tte_row_check (
  input  logic                        clk,
  input  tte_pkg::chk_ctrl_t          ctrl,
  input  logic [tte_pkg::MAX_COLS-1:0] row,
  input  logic [tte_pkg::MAX_COLS-1:0] mask,
  output tte_pkg::chk_stat_t          stat
);

  import tte_pkg::*;

  logic [MAX_COLS-1:0] owned;
  logic [MAX_COLS-1:0] owned_next;
  logic [MAX_COLS-1:0] hit;
  logic                single;

  // Chosen columns hit by this row; a single hit means that column owns it
  always_comb begin
    hit        = row & mask;
    single     = ((hit & (hit - MAX_COLS'(1))) == '0);
    owned_next = (single && (hit != '0)) ? (owned | hit) : owned;
    stat.miss    = (hit == '0);
    stat.typical = (owned_next == mask);
  end

  // Owned-column accumulator
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      owned <= '0;
    end else if (ctrl.load) begin
      owned <= owned_next;
    end
  end

endmodule

// ----- hw/rtl/typical_testor_enumerator.sv -----
// Typical testor enumerator, top level: command port, sequencer, row store.
// Uses tte_pkg, tte_ram and tte_row_check.
`timescale 1ns / 1ps

// A transaction is taken when start is high and busy is low; its one result
// appears on testor_mask/status/rows_held with done high for exactly one
// cycle, and the receiver cannot stall it. Append, clear and unused opcodes
// are answered without a walk. A fetch walks candidate masks upward from
// where the last one stopped; each candidate reads rows until the first row
// that misses it, or all stored rows, through the single row check unit,
// the store delivering one row per cycle from its read port. A fetch with
// no rows stored or an exhausted walk answers ST_DONE without a walk. num_cols
// is written through cfg_wr_en/cfg_wr_data; the user must do so only while
// no fetch is in progress, as the block itself does not enforce it;
// a value of 0 acts as 1 and a value above 16 as 16.
module typical_testor_enumerator #(
  parameter  int MAX_ROWS = tte_pkg::MAX_ROWS_DEF,
  localparam int ROWS_W   = $clog2(MAX_ROWS + 1),
  localparam int ADDR_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  // Configuration
  input  logic                         cfg_wr_en,
  input  logic [tte_pkg::NCOLS_W-1:0]  cfg_wr_data,
  // Command
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   action,
  input  logic [tte_pkg::MAX_COLS-1:0] row_bits,
  // Result
  output logic                         done,
  output logic [tte_pkg::MAX_COLS-1:0] testor_mask,
  output logic [1:0]                   status,
  output logic [ROWS_W-1:0]            rows_held
);

  import tte_pkg::*;

  fsm_state_t          state, state_next;
  logic [NCOLS_W-1:0]  num_cols;
  logic [ROWS_W-1:0]   count, count_next;
  logic [CAND_W-1:0]   cand, cand_next;
  logic [MAX_COLS-1:0] mask, mask_next;
  logic [ROWS_W-1:0]   ridx, ridx_next;
  logic                rd_valid, rd_valid_next;
  logic                rd_last, rd_last_next;
  logic                done_next;
  logic [MAX_COLS-1:0] res_mask, res_mask_next;
  status_t             res_status, res_status_next;

  logic [NCOLS_W-1:0]  cols_eff;
  logic [CAND_W-1:0]   limit;
  logic [CAND_W-1:0]   mask_inc;
  logic                issue;
  logic                wr_en, rd_en;
  logic [MAX_COLS-1:0] rd_data;
  chk_ctrl_t           chk_ctrl;
  chk_stat_t           chk_stat;

  // Row store
  tte_ram #(
    .WIDTH  (MAX_COLS),
    .DEPTH  (MAX_ROWS),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[ADDR_W-1:0]),
    .wr_data (row_bits),
    .rd_en   (rd_en),
    .rd_addr (ridx[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  // Shared row check unit
  tte_row_check u_chk (
    .clk  (clk),
    .ctrl (chk_ctrl),
    .row  (rd_data),
    .mask (mask),
    .stat (chk_stat)
  );

  // Columns in use, clamped, and the end of the walk
  always_comb begin
    if (num_cols == '0) begin
      cols_eff = NCOLS_W'(1);
    end else if (num_cols > NCOLS_W'(MAX_COLS)) begin
      cols_eff = NCOLS_W'(MAX_COLS);
    end else begin
      cols_eff = num_cols;
    end
    limit    = CAND_W'(1) << cols_eff;
    mask_inc = {1'b0, mask} + CAND_W'(1);
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      num_cols <= NCOLS_RESET;
    end else if (cfg_wr_en) begin
      num_cols <= cfg_wr_data;
    end
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      cand     <= CAND_W'(1);
      rd_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      cand     <= cand_next;
      rd_valid <= rd_valid_next;
      done     <= done_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    mask       <= mask_next;
    ridx       <= ridx_next;
    rd_last    <= rd_last_next;
    res_mask   <= res_mask_next;
    res_status <= res_status_next;
  end

  // Next state and control
  always_comb begin
    state_next      = state;
    count_next      = count;
    cand_next       = cand;
    mask_next       = mask;
    ridx_next       = ridx;
    rd_valid_next   = rd_valid;
    rd_last_next    = rd_last;
    done_next       = 1'b0;
    res_mask_next   = res_mask;
    res_status_next = res_status;
    wr_en           = 1'b0;
    rd_en           = 1'b0;
    issue           = 1'b0;
    chk_ctrl        = '0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          done_next     = 1'b1;
          res_mask_next = '0;
          case (action)
            ACT_APPEND: begin
              if (count < ROWS_W'(MAX_ROWS)) begin
                wr_en           = 1'b1;
                count_next      = count + ROWS_W'(1);
                cand_next       = CAND_W'(1);
                res_status_next = ST_STORED;
              end else begin
                res_status_next = ST_FULL;
              end
            end
            ACT_FETCH: begin
              if ((cand >= limit) || (count == '0)) begin
                // nothing left to walk, or no row makes any column needed
                res_status_next = ST_DONE;
                if (cand < limit) begin
                  cand_next = limit;
                end
              end else begin
                done_next      = 1'b0;
                mask_next      = cand[MAX_COLS-1:0];
                ridx_next      = '0;
                rd_valid_next  = 1'b0;
                chk_ctrl.clear = 1'b1;
                state_next     = S_SCAN;
              end
            end
            ACT_CLEAR: begin
              count_next      = '0;
              cand_next       = CAND_W'(1);
              res_status_next = ST_STORED;
            end
            default: begin
              res_status_next = ST_STORED;
            end
          endcase
        end
      end

      S_SCAN: begin
        // issue one row read a cycle, check the row read the cycle before
        issue         = (ridx < count);
        rd_en         = issue;
        rd_valid_next = issue;
        rd_last_next  = issue && (ridx == (count - ROWS_W'(1)));
        ridx_next     = issue ? (ridx + ROWS_W'(1)) : ridx;
        chk_ctrl.load = rd_valid;

        if (rd_valid && (chk_stat.miss || rd_last)) begin
          // candidate decided: drop reads in flight and restart the row walk
          chk_ctrl.clear = 1'b1;
          rd_valid_next  = 1'b0;
          ridx_next      = '0;
          if (!chk_stat.miss && chk_stat.typical) begin
            res_mask_next   = mask;
            res_status_next = ST_FOUND;
            cand_next       = mask_inc;
            done_next       = 1'b1;
            state_next      = S_IDLE;
          end else if (mask_inc >= limit) begin
            res_mask_next   = '0;
            res_status_next = ST_DONE;
            cand_next       = limit;
            done_next       = 1'b1;
            state_next      = S_IDLE;
          end else begin
            mask_next = mask_inc[MAX_COLS-1:0];
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Outputs
  assign busy        = (state != S_IDLE);
  assign testor_mask = res_mask;
  assign status      = res_status;
  assign rows_held   = count;

`ifndef ASSERT_OFF
  // A result only follows an accepted command or the end of a walk
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(start && !busy) || $past(state == S_SCAN)))
    else $error("result strobe without a transaction");

  // A found testor is never empty and lies below the column limit
  a_found_mask: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_FOUND)) |-> ((testor_mask != '0) &&
      ({1'b0, testor_mask} < limit)))
    else $error("found testor out of range");

  // Row count never passes the store depth
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= ROWS_W'(MAX_ROWS))
    else $error("row count beyond store depth");

  // A walk only runs with rows stored and a candidate below the limit
  a_scan_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> ((count != '0) && ({1'b0, mask} < limit)))
    else $error("walk running with no rows or past the limit");
`endif

endmodule

// ----- test/tb.sv -----
// Self-checking bench for the typical testor enumerator: directed and random
// transactions, a predictor of stored rows and of the candidate walk.
// Depends on tte_pkg and typical_testor_enumerator.
`timescale 1ns / 1ps

module tb;
  import tte_pkg::*;

  localparam int STORE_DEPTH  = MAX_ROWS_DEF;
  localparam int RANDOM_ITEMS = 120;
  localparam int WATCHDOG     = 300000;  // watchdog limit between accepted commands and results
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // One expected answer of the block
  typedef struct {
    logic [MAX_COLS-1:0] mask;
    status_t             st;
    int unsigned         held;
  } answer_t;

  // Predictor: row store, walk position and column count, plus answer queue
  class testor_tracker;
    bit [MAX_COLS-1:0] rows [STORE_DEPTH];
    int unsigned held;
    int unsigned next_mask;
    int unsigned ncols;
    int          errors;
    answer_t     pending_answers [$];

    function new();
      held      = 0;
      next_mask = 1;
      ncols     = MAX_COLS;
      errors    = 0;
    endfunction

    function void set_cols(logic [NCOLS_W-1:0] v);
      ncols = v;
    endfunction

    // every row hit, and every chosen column owns a row hit by it alone
    function bit covers_typically(int unsigned m);
      int unsigned owned;
      int unsigned hit;
      owned = 0;
      for (int r = 0; r < held; r++) begin
        hit = rows[r] & m;
        if (hit == 0) return 1'b0;
        if ((hit & (hit - 1)) == 0) owned |= hit;
      end
      return owned == m;
    endfunction

    function void take_command(logic [1:0] a, logic [MAX_COLS-1:0] r);
      answer_t     ans;
      int unsigned cols;
      int unsigned lim;
      int unsigned m;
      bit          found;
      ans.mask = '0;
      ans.st   = ST_STORED;
      case (a)
        ACT_APPEND: begin
          if (held < STORE_DEPTH) begin
            rows[held] = r;
            held++;
            next_mask = 1;
          end else begin
            ans.st = ST_FULL;
          end
        end
        ACT_FETCH: begin
          cols = (ncols < 1) ? 1 : (ncols > MAX_COLS) ? MAX_COLS : ncols;
          lim  = 1 << cols;
          m    = (next_mask < 1) ? 1 : next_mask;
          found = 1'b0;
          while (m < lim && !found) begin
            if (covers_typically(m)) found = 1'b1;
            else m++;
          end
          if (found) begin
            ans.mask  = m[MAX_COLS-1:0];
            ans.st    = ST_FOUND;
            next_mask = m + 1;
          end else begin
            ans.st = ST_DONE;
            if (next_mask < lim) next_mask = lim;
          end
        end
        ACT_CLEAR: begin
          held      = 0;
          next_mask = 1;
        end
        default: ;  // unused code: nothing changes
      endcase
      ans.held = held;
      pending_answers.insert(pending_answers.size(), ans);
    endfunction

    function void check_answer(logic [MAX_COLS-1:0] m, logic [1:0] st, logic [6:0] h);
      answer_t e;
      if (pending_answers.size() == 0) begin
        $display("%0t: result with nothing expected: mask %h status %0d rows %0d",
                 $time, m, st, h);
        errors++;
        return;
      end
      e = pending_answers.pop_front();
      if (m !== e.mask) begin
        $display("%0t: testor_mask expected %h got %h", $time, e.mask, m);
        errors++;
      end
      if (st !== e.st) begin
        $display("%0t: status expected %0d got %0d", $time, e.st, st);
        errors++;
      end
      if (h !== 7'(e.held)) begin
        $display("%0t: rows_held expected %0d got %0d", $time, e.held, h);
        errors++;
      end
    endfunction
  endclass

  logic                clk         = 1'b0;
  logic                rst         = 1'b1;
  logic                cfg_wr_en   = 1'b0;
  logic [NCOLS_W-1:0]  cfg_wr_data = '0;
  logic                start       = 1'b0;
  logic                busy;
  logic [1:0]          action      = ACT_APPEND;
  logic [MAX_COLS-1:0] row_bits    = '0;
  logic                done;
  logic [MAX_COLS-1:0] testor_mask;
  logic [1:0]          status;
  logic [6:0]          rows_held;

  testor_tracker tracker = new();
  int sender_idle_pct = 31;
  int cur_cols        = MAX_COLS;  // effective column count, driver side
  int issued          = 0;
  int quiet           = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  typical_testor_enumerator DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .start       (start),
    .busy        (busy),
    .action      (action),
    .row_bits    (row_bits),
    .done        (done),
    .testor_mask (testor_mask),
    .status      (status),
    .rows_held   (rows_held)
  );

  // Monitor: register writes, accepted transactions, results, watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_wr_en) tracker.set_cols(cfg_wr_data);
      if (start && !busy) tracker.take_command(action, row_bits);
      if (done === 1'b1) tracker.check_answer(testor_mask, status, rows_held);
      if ((start && !busy) || done === 1'b1) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG) begin
        $display("%0t: watchdog expired", $time);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic int eff_cols(int v);
    return (v < 1) ? 1 : (v > MAX_COLS) ? MAX_COLS : v;
  endfunction

  // Row with sparse or random content in the columns in use
  function automatic logic [MAX_COLS-1:0] pick_row(int c);
    int unsigned low;
    int unsigned r;
    low = (1 << c) - 1;
    case ($urandom_range(0, 3))
      0: r = $urandom;
      1: r = ($urandom & ~low) | (1 << $urandom_range(0, c - 1));
      2: r = ($urandom & ~low) | (1 << $urandom_range(0, c - 1))
             | (1 << $urandom_range(0, c - 1));
      default: r = $urandom & $urandom & low;
    endcase
    return r[MAX_COLS-1:0];
  endfunction

  // Offer one transaction after a random gap and hold it until taken
  task automatic do_cmd(logic [1:0] a, logic [MAX_COLS-1:0] r);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    action   <= a;
    row_bits <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    issued++;
  endtask

  // Write num_cols once every answer is in and the block is idle
  task automatic write_cols(int v);
    start <= 1'b0;
    @(posedge clk);
    while (tracker.pending_answers.size() != 0 || busy) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= NCOLS_W'(v);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_cols = eff_cols(v);
  endtask

  // Random episode: set columns, load rows, walk the list with some noise
  task automatic run_episode(bit fill);
    int n;
    int v;
    v = ($urandom_range(0, 99) < 10) ? 0 : $urandom_range(1, 6);
    write_cols(v);
    if (fill || $urandom_range(0, 99) < 85) do_cmd(ACT_CLEAR, MAX_COLS'($urandom));
    n = fill ? STORE_DEPTH : $urandom_range(0, 6);
    repeat (n) do_cmd(ACT_APPEND, pick_row(cur_cols));
    n = $urandom_range(2, 12);
    repeat (n) begin
      if ($urandom_range(0, 99) < 12) begin
        case ($urandom_range(0, 2))
          0: do_cmd(ACT_UNUSED, MAX_COLS'($urandom));
          1: do_cmd(ACT_APPEND, pick_row(cur_cols));
          default: do_cmd(ACT_CLEAR, MAX_COLS'($urandom));
        endcase
      end else begin
        do_cmd(ACT_FETCH, MAX_COLS'($urandom));
      end
    end
    // store full: row dropped, walk carries on
    if (fill) begin
      do_cmd(ACT_APPEND, pick_row(cur_cols));
      repeat (4) do_cmd(ACT_FETCH, MAX_COLS'($urandom));
    end
  endtask

  initial begin
    int first_random;
    int episode;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty store, unused code, 16 columns from reset
    do_cmd(ACT_FETCH, 16'h0000);
    do_cmd(ACT_UNUSED, 16'hA5A5);
    do_cmd(ACT_APPEND, 16'hFFFF);
    do_cmd(ACT_FETCH, 16'h0000);
    do_cmd(ACT_FETCH, 16'hFFFF);
    // column count cut mid walk: the walk stops at the new limit
    write_cols(2);
    do_cmd(ACT_FETCH, 16'h0000);
    do_cmd(ACT_FETCH, 16'h0000);
    // zero columns acts as one; an all-zero row defeats every mask
    write_cols(0);
    do_cmd(ACT_APPEND, 16'h0000);
    do_cmd(ACT_FETCH, 16'h0000);
    do_cmd(ACT_CLEAR, 16'h0000);
    do_cmd(ACT_APPEND, 16'h5555);
    do_cmd(ACT_FETCH, 16'h0000);
    do_cmd(ACT_FETCH, 16'h0000);
    // above the maximum acts as 16: top column alone, full walk
    write_cols(31);
    do_cmd(ACT_CLEAR, 16'hFFFF);
    do_cmd(ACT_APPEND, 16'h8000);
    do_cmd(ACT_FETCH, 16'h0000);
    do_cmd(ACT_FETCH, 16'h0000);

    // Random episodes, idling shifts by thirds of the run
    first_random = issued;
    episode = 0;
    while (issued - first_random < RANDOM_ITEMS) begin
      if (issued - first_random < RANDOM_ITEMS / 3) sender_idle_pct = 31;
      else if (issued - first_random < 2 * RANDOM_ITEMS / 3) sender_idle_pct = 81;
      else sender_idle_pct = 0;
      run_episode(episode == 2);
      episode++;
    end

    // Drain
    start <= 1'b0;
    while (tracker.pending_answers.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending_answers.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
